@@ src/mf2d_pkg.sv @@
`default_nettype none
package mf2d_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxRadius = 3;
    localparam int MaxHeight = 4096;
    localparam int LineRows  = 3 * MaxRadius + 1;
    localparam int StoreDepth = LineRows * MaxWidth;
    localparam int AddrW = $clog2(StoreDepth);
    localparam int ColW = $clog2(MaxWidth);
    localparam int RowW = $clog2(MaxHeight);
    localparam int SlotW = $clog2(LineRows);
    localparam int TapW = $clog2(2 * MaxRadius + 1);
    localparam int WinMax = (2 * MaxRadius + 1) * (2 * MaxRadius + 1);
    localparam int CntW = $clog2(WinMax + 1);
    localparam int WinDepth = 2 ** CntW;

    localparam logic [1:0] RegRadius = 2'd0;
    localparam logic [1:0] RegWidth  = 2'd1;
    localparam logic [1:0] RegHeight = 2'd2;

    localparam logic CmdPixel = 1'b0;
    localparam logic CmdDrain = 1'b1;
endpackage
`default_nettype wire

@@ src/mf2d_ram.sv @@
`default_nettype none
module mf2d_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ src/median_filter_2d_replicate.sv @@
`default_nettype none
// Streaming 2-D median filter with replicate borders. Pixels arrive in
// raster order on s_axis (tuser = command: 0 pixel, 1 drain); each accepted
// pixel whose raster index reaches radius*width+radius yields one median on
// m_axis, and after the last pixel each drain request yields one of the
// remaining medians. tlast marks the last median of a frame. The line store
// and the window buffer are block memories with one read port each, so an
// item that yields a median keeps the engine busy through the accept, the
// fetch of the N = (2R+1)^2 window taps, K rank passes (K, from 1 to N, is
// the window position of the first tap whose rank is the median) and the
// post of the result; the post waits while an earlier median is still held
// on m_axis. An item with no result leaves the engine idle. The next
// request is accepted as soon as the engine is idle, even while a finished
// median waits in the output register. Configuration writes are taken only
// while the engine is idle and no median is pending, win over a request in
// the same cycle, and restart the frame when they address registers 0 to 2.
module median_filter_2d_replicate
    import mf2d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  wire logic        s_axis_tuser,   // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [7:0] median_out
    output logic             m_axis_tlast,   // frame_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StRead  = 3'd1;
    localparam logic [2:0] StSort  = 3'd2;
    localparam logic [2:0] StDone  = 3'd3;
    localparam logic [2:0] StCand  = 3'd4;
    localparam logic [2:0] StLoad  = 3'd5;

    logic [1:0]  radius_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [ColW-1:0] in_col_reg, out_col_reg;
    logic [RowW-1:0] in_row_reg, out_row_reg;
    logic [SlotW-1:0] in_slot_reg, out_slot_reg;
    logic in_done_reg;
    logic [2:0] state_reg;
    logic [CntW-1:0] tap_reg, i_reg, j_reg;
    logic [TapW-1:0] dy_reg, dx_reg;
    logic [CntW-1:0] lt_reg, le_reg;
    logic [7:0] cand_reg, med_reg;
    logic ovalid_reg, olast_reg;

    // Effective configuration
    logic [1:0]  r_eff;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    always_comb
    begin
        r_eff = (radius_reg > 2'(MaxRadius)) ? 2'(MaxRadius) : radius_reg;
        w_eff = (width_reg == 11'd0) ? 11'd1 :
                (width_reg > 11'(MaxWidth)) ? 11'(MaxWidth) : width_reg;
        h_eff = (height_reg == 13'd0) ? 13'd1 :
                (height_reg > 13'(MaxHeight)) ? 13'(MaxHeight) : height_reg;
    end

    logic [3:0] side;
    logic [CntW-1:0] ntap;
    assign side = {1'b0, r_eff, 1'b0} + 4'd1;
    assign ntap = CntW'(side) * CntW'(side);

    // Raster index of the input pixel against the lag, tracked by counter
    logic [23:0] lag_cnt_reg;
    logic [23:0] lag;
    assign lag = 24'(r_eff) * 24'(w_eff) + 24'(r_eff);

    logic s_acc, cfg_acc, busy, post;
    assign busy = (state_reg != StIdle);
    assign cfg_ready = !busy && !ovalid_reg;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign s_axis_tready = !busy && !cfg_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign post = (state_reg == StDone) && (!ovalid_reg || m_axis_tready);

    logic in_last, pix_emit, start_emit;
    assign in_last = (in_row_reg >= RowW'(h_eff - 13'd1)) &&
                     (in_col_reg >= ColW'(w_eff - 11'd1));
    assign pix_emit = s_acc && s_axis_tuser == CmdPixel && !in_done_reg &&
                      (lag_cnt_reg >= lag);
    assign start_emit = pix_emit ||
                        (s_acc && s_axis_tuser == CmdDrain && in_done_reg);

    // Window tap address, clamped coordinates; ring slot relative to the output row
    logic signed [RowW+1:0] ty;
    logic signed [ColW+1:0] tx;
    logic [RowW-1:0] cy;
    logic [ColW-1:0] cx;
    logic signed [RowW+1:0] dyc;
    logic signed [SlotW+1:0] sl;
    logic [SlotW-1:0] cslot;
    always_comb
    begin
        ty = $signed({2'b00, out_row_reg}) + $signed((RowW+2)'(dy_reg))
             - $signed((RowW+2)'(r_eff));
        tx = $signed({2'b00, out_col_reg}) + $signed((ColW+2)'(dx_reg))
             - $signed((ColW+2)'(r_eff));
        if (ty < 0) cy = '0;
        else if (ty > $signed((RowW+2)'(h_eff) - (RowW+2)'(1)))
            cy = RowW'(h_eff - 13'd1);
        else cy = RowW'(ty);
        if (tx < 0) cx = '0;
        else if (tx > $signed((ColW+2)'(w_eff) - (ColW+2)'(1)))
            cx = ColW'(w_eff - 11'd1);
        else cx = ColW'(tx);
        dyc = $signed({2'b00, cy}) - $signed({2'b00, out_row_reg});
        sl = $signed({2'b00, out_slot_reg}) + $signed(dyc[SlotW+1:0]);
        if (sl < 0)
            sl = sl + $signed((SlotW+2)'(LineRows));
        else if (sl >= $signed((SlotW+2)'(LineRows)))
            sl = sl - $signed((SlotW+2)'(LineRows));
        cslot = SlotW'(sl);
    end

    logic wr_en;
    logic [AddrW-1:0] wr_addr, rd_addr;
    logic [7:0] rd_data;
    assign wr_en = s_acc && s_axis_tuser == CmdPixel && !in_done_reg;
    assign wr_addr = AddrW'(in_slot_reg) * AddrW'(MaxWidth) + AddrW'(in_col_reg);
    assign rd_addr = AddrW'(cslot) * AddrW'(MaxWidth) + AddrW'(cx);

    mf2d_ram #(.Width(8), .Depth(StoreDepth)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Window buffer: filled during the fetch, scanned once per rank pass
    logic win_wr_en;
    logic [CntW-1:0] win_wr_addr, win_rd_addr;
    logic [7:0] win_rd_data;
    assign win_wr_en = (state_reg == StRead) && (tap_reg != '0);
    assign win_wr_addr = tap_reg - CntW'(1);
    always_comb
    begin
        case (state_reg)
            StCand:  win_rd_addr = i_reg;
            StSort:  win_rd_addr = j_reg;
            default: win_rd_addr = '0;
        endcase
    end

    mf2d_ram #(.Width(8), .Depth(WinDepth)) u_win (
        .clk     (clk),
        .wr_en   (win_wr_en),
        .wr_addr (win_wr_addr),
        .wr_data (rd_data),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    // Running rank counts including the tap read back this cycle
    logic [CntW-1:0] lt_fin, le_fin, half;
    assign lt_fin = lt_reg + CntW'(win_rd_data < cand_reg);
    assign le_fin = le_reg + CntW'(win_rd_data <= cand_reg);
    assign half = ntap >> 1;

    logic out_last;
    assign out_last = (out_row_reg == RowW'(h_eff - 13'd1)) &&
                      (out_col_reg == ColW'(w_eff - 11'd1));

    // Control, counters and the rank-select engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 2'd1;
            width_reg <= 11'd640;
            height_reg <= 13'd480;
            in_col_reg <= '0;
            in_row_reg <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_slot_reg <= '0;
            in_done_reg <= 1'b0;
            lag_cnt_reg <= '0;
            state_reg <= StIdle;
            ovalid_reg <= 1'b0;
            olast_reg <= 1'b0;
            med_reg <= '0;
            cand_reg <= '0;
            tap_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            lt_reg <= '0;
            le_reg <= '0;
            dy_reg <= '0;
            dx_reg <= '0;
        end
        else
        begin
            // Hold the result until taken; post a new one when the slot frees
            if (post)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_acc)
            begin
                case (cfg_index)
                    RegRadius: radius_reg <= cfg_data[1:0];
                    RegWidth:  width_reg <= cfg_data[10:0];
                    RegHeight: height_reg <= cfg_data;
                    default: ;
                endcase
                if (cfg_index <= RegHeight)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    in_slot_reg <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    out_slot_reg <= '0;
                    in_done_reg <= 1'b0;
                    lag_cnt_reg <= '0;
                end
            end
            // Advance input position
            if (wr_en)
            begin
                lag_cnt_reg <= lag_cnt_reg + 24'd1;
                if (in_last)
                begin
                    in_done_reg <= 1'b1;
                end
                else if (in_col_reg >= ColW'(w_eff - 11'd1))
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RowW'(1);
                    in_slot_reg <= (in_slot_reg == SlotW'(LineRows - 1)) ? '0
                                   : in_slot_reg + SlotW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + ColW'(1);
                end
            end
            case (state_reg)
                StIdle:
                begin
                    if (start_emit)
                    begin
                        state_reg <= StRead;
                        dy_reg <= '0;
                        dx_reg <= '0;
                        tap_reg <= '0;
                    end
                end
                StRead:
                begin
                    // Issue one read per tap; the store's registered read data is written to the window
                    if (tap_reg == ntap)
                    begin
                        state_reg <= StCand;
                        i_reg <= '0;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + CntW'(1);
                        if (dx_reg == TapW'(side - 4'd1))
                        begin
                            dx_reg <= '0;
                            dy_reg <= dy_reg + TapW'(1);
                        end
                        else
                        begin
                            dx_reg <= dx_reg + TapW'(1);
                        end
                    end
                end
                StCand:
                begin
                    // Read candidate i
                    state_reg <= StLoad;
                end
                StLoad:
                begin
                    // Latch the candidate and start the scan at tap 0
                    cand_reg <= win_rd_data;
                    j_reg <= CntW'(1);
                    lt_reg <= '0;
                    le_reg <= '0;
                    state_reg <= StSort;
                end
                StSort:
                begin
                    // Rank candidate i: count smaller and not-greater taps
                    if (j_reg == ntap)
                    begin
                        if (lt_fin <= half && le_fin > half)
                        begin
                            state_reg <= StDone;
                        end
                        else
                        begin
                            i_reg <= i_reg + CntW'(1);
                            state_reg <= StCand;
                        end
                    end
                    else
                    begin
                        lt_reg <= lt_fin;
                        le_reg <= le_fin;
                        j_reg <= j_reg + CntW'(1);
                    end
                end
                StDone:
                begin
                    if (post)
                    begin
                        med_reg <= cand_reg;
                        olast_reg <= out_last;
                        state_reg <= StIdle;
                        if (out_last)
                        begin
                            in_col_reg <= '0;
                            in_row_reg <= '0;
                            in_slot_reg <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            out_slot_reg <= '0;
                            in_done_reg <= 1'b0;
                            lag_cnt_reg <= '0;
                        end
                        else if (out_col_reg >= ColW'(w_eff - 11'd1))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + RowW'(1);
                            out_slot_reg <= (out_slot_reg == SlotW'(LineRows - 1)) ? '0
                                            : out_slot_reg + SlotW'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + ColW'(1);
                        end
                    end
                end
                default: state_reg <= StIdle;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = med_reg;
    assign m_axis_tlast = olast_reg;

    // A result must not be overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    // No request is taken while the engine is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != StIdle) |-> !s_axis_tready)
        else $error("request taken while busy");
    // Engine finishing always posts a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StDone) |=> m_axis_tvalid)
        else $error("result missing");
endmodule
`default_nettype wire
